// File: rtl/core/gla_pkg.sv
package gla_pkg;

    // fixed field widths of the request and response
    localparam int QUBIT_W = 6;
    localparam int LAYER_W = 12;
    localparam int DEPTH_W = 13;

    // one gate request
    typedef struct packed {
        logic               circuit_start;
        logic [QUBIT_W-1:0] qubit_a;
        logic [QUBIT_W-1:0] qubit_b;
        logic               two_qubit;
    } t_gate_req;

    // one layer response
    typedef struct packed {
        logic [LAYER_W-1:0] gate_layer;
        logic [DEPTH_W-1:0] circuit_depth;
        logic               saturated;
    } t_gate_rsp;

endpackage

// File: rtl/core/gate_layer_assigner.sv
// channel   | valid    | ready    | payload
// ----------+----------+----------+-----------------------
// gate in   | i_valid  | o_ready  | i_req (t_gate_req)
// layer out | o_valid  | i_ready  | o_rsp (t_gate_rsp)
//
// One gate per cycle sustained while i_ready holds; a taken gate is registered in
// the middle stage, then in the response register. The qubit table sits in two
// banks (one per write port) read at both qubits on take; per-entry bank select
// and valid bits pick the live value, and the previous gate's write is forwarded.
// Reset (synchronous, active low) clears the pipeline, valid bits and running
// maximum, so no clearing pass is needed. A stalled output holds both stages.
module gate_layer_assigner
    import gla_pkg::*;
#(
    parameter int NUM_QUBITS = 64,
    parameter int MAX_LAYERS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_gate_req i_req,
    output logic      o_valid,
    input  logic      i_ready,
    output t_gate_rsp o_rsp
);

    localparam int QW = $clog2(NUM_QUBITS);
    localparam int LW = $clog2(MAX_LAYERS);
    localparam int EW = (LW + 1 > DEPTH_W) ? LW + 1 : DEPTH_W;
    localparam logic [LW-1:0] TOP_LAYER = LW'(MAX_LAYERS - 1);

    // table banks, bank a takes the first qubit write, bank b the second
    logic [LW-1:0] r_mem_a [NUM_QUBITS];
    logic [LW-1:0] r_mem_b [NUM_QUBITS];
    logic [NUM_QUBITS-1:0] r_lvt;
    logic [NUM_QUBITS-1:0] r_valid;
    logic [NUM_QUBITS-1:0] n_valid;
    logic [NUM_QUBITS-1:0] n_lvt;
    logic [LW-1:0] r_max;
    logic [LW-1:0] n_max;

    // middle stage
    logic          r_s1_v;
    logic          r_s1_start;
    logic          r_s1_two;
    logic          r_s1_ina;
    logic          r_s1_inb;
    logic [QW-1:0] r_s1_ia;
    logic [QW-1:0] r_s1_ib;
    logic [LW-1:0] r_rd_aa;
    logic [LW-1:0] r_rd_ab;
    logic [LW-1:0] r_rd_ba;
    logic [LW-1:0] r_rd_bb;

    // write seen by the gate in the middle stage at its read edge
    logic          r_fwd_a_en;
    logic          r_fwd_b_en;
    logic [QW-1:0] r_fwd_ia;
    logic [QW-1:0] r_fwd_ib;
    logic [LW-1:0] r_fwd_val;

    // output register
    logic      r_out_v;
    t_gate_rsp r_out;

    logic          load;
    logic          adv;
    logic [QW-1:0] in_ia;
    logic [QW-1:0] in_ib;
    logic          in_ina;
    logic          in_inb;
    logic [LW-1:0] raw_a;
    logic [LW-1:0] raw_b;
    logic [LW-1:0] ent_a;
    logic [LW-1:0] ent_b;
    logic [LW-1:0] layer;
    logic [LW-1:0] nxt;
    logic          wr_a_en;
    logic          wr_b_en;
    logic [EW-1:0] layer_x;
    logic [EW-1:0] depth_x;

    // handshake
    assign adv     = r_s1_v && (!r_out_v || i_ready);
    assign o_ready = !r_s1_v || adv;
    assign load    = i_valid && o_ready;
    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

    // request decode
    assign in_ia  = QW'(i_req.qubit_a);
    assign in_ib  = QW'(i_req.qubit_b);
    assign in_ina = 32'(i_req.qubit_a) < NUM_QUBITS;
    assign in_inb = 32'(i_req.qubit_b) < NUM_QUBITS;

    // live entry of each qubit
    always_comb begin
        raw_a = r_lvt[r_s1_ia] ? r_rd_ba : r_rd_aa;
        if ((r_fwd_a_en && r_fwd_ia == r_s1_ia) || (r_fwd_b_en && r_fwd_ib == r_s1_ia)) begin
            raw_a = r_fwd_val;
        end
        raw_b = r_lvt[r_s1_ib] ? r_rd_bb : r_rd_ab;
        if ((r_fwd_a_en && r_fwd_ia == r_s1_ib) || (r_fwd_b_en && r_fwd_ib == r_s1_ib)) begin
            raw_b = r_fwd_val;
        end
        ent_a = (r_s1_ina && r_valid[r_s1_ia] && !r_s1_start) ? raw_a : '0;
        ent_b = (r_s1_two && r_s1_inb && r_valid[r_s1_ib] && !r_s1_start) ? raw_b : '0;
    end

    // layer, next free layer and running maximum
    always_comb begin
        layer = (ent_b > ent_a) ? ent_b : ent_a;
        if (layer > TOP_LAYER) begin
            layer = TOP_LAYER;
        end
        nxt = (layer < TOP_LAYER) ? layer + LW'(1) : TOP_LAYER;
        n_max = r_s1_start ? '0 : r_max;
        if (layer > n_max) begin
            n_max = layer;
        end
        layer_x = EW'(layer);
        depth_x = EW'(n_max) + EW'(1);
    end

    // write enables; a repeated qubit goes to bank a only
    assign wr_a_en = adv && r_s1_ina;
    assign wr_b_en = adv && r_s1_two && r_s1_inb && !(r_s1_ina && r_s1_ia == r_s1_ib);

    // valid bits and bank select update
    always_comb begin
        n_valid = r_s1_start ? '0 : r_valid;
        n_lvt   = r_lvt;
        if (wr_a_en) begin
            n_valid[r_s1_ia] = 1'b1;
            n_lvt[r_s1_ia]   = 1'b0;
        end
        if (wr_b_en) begin
            n_valid[r_s1_ib] = 1'b1;
            n_lvt[r_s1_ib]   = 1'b1;
        end
    end

    // table banks: read at take, write when the gate leaves the middle stage
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rd_aa <= r_mem_a[in_ia];
            r_rd_ab <= r_mem_a[in_ib];
            r_rd_ba <= r_mem_b[in_ia];
            r_rd_bb <= r_mem_b[in_ib];
        end
        if (wr_a_en) begin
            r_mem_a[r_s1_ia] <= nxt;
        end
        if (wr_b_en) begin
            r_mem_b[r_s1_ib] <= nxt;
        end
    end

    // middle stage payload and forwarded write
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_start <= i_req.circuit_start;
            r_s1_two   <= i_req.two_qubit;
            r_s1_ina   <= in_ina;
            r_s1_inb   <= in_inb;
            r_s1_ia    <= in_ia;
            r_s1_ib    <= in_ib;
            r_fwd_a_en <= wr_a_en;
            r_fwd_b_en <= wr_b_en;
            r_fwd_ia   <= r_s1_ia;
            r_fwd_ib   <= r_s1_ib;
            r_fwd_val  <= nxt;
        end
        if (adv) begin
            r_lvt                  <= n_lvt;
            r_out.gate_layer       <= layer_x[LAYER_W-1:0];
            r_out.circuit_depth    <= depth_x[DEPTH_W-1:0];
            r_out.saturated        <= n_max >= TOP_LAYER;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_valid <= '0;
            r_max   <= '0;
        end else begin
            if (load) begin
                r_s1_v <= 1'b1;
            end else if (adv) begin
                r_s1_v <= 1'b0;
            end
            if (adv) begin
                r_out_v <= 1'b1;
                r_valid <= n_valid;
                r_max   <= n_max;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule
